### hw/rtl/itr_pkg.sv
// Shared types and constants for the integer to radix digit converter.
`default_nettype none
package itr_pkg;

  localparam int unsigned ValueWidthDefault = 64;
  localparam int unsigned ValueBits         = 64;
  localparam int unsigned DigitBits         = 8;
  localparam int unsigned RadixBits         = 9;

  localparam logic [RadixBits-1:0] RadixReset = 9'd10;
  localparam logic [RadixBits-1:0] RadixMin   = 9'd2;
  localparam logic [RadixBits-1:0] RadixMax   = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_t;

  // Out-of-range bases are folded back into the supported span.
  function automatic logic [RadixBits-1:0] clamp_radix(input logic [RadixBits-1:0] r);
    logic [RadixBits-1:0] res;
    res = r;
    if (r < RadixMin) begin
      res = RadixMin;
    end else if (r > RadixMax) begin
      res = RadixMax;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/itr_channels.sv
// Valid/ready channel interfaces for value requests, digit results and the radix register.
`default_nettype none

interface itr_value_if import itr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itr_digit_if import itr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DigitBits-1:0] digit;
  logic                 last;
  modport source (output valid, output digit, output last, input ready);
  modport sink   (input valid, input digit, input last, output ready);
endinterface

interface itr_cfg_if import itr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RadixBits-1:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

### hw/rtl/integer_to_radix_digits.sv
// The request is taken in idle; the bit-serial divider then produces each digit, and
// each digit is then read from the digit store and presented in the output register.
// The divider performs restoring division by the radix, one quotient bit per cycle.
// A new request is taken while the final digit still waits in the output register.
// Reset (synchronous, rst high) returns to idle with no result pending and radix 10.
`default_nettype none
module integer_to_radix_digits import itr_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire            clk,
  input  wire            rst,
  itr_cfg_if.sink        cfg,
  itr_value_if.sink      din,
  itr_digit_if.source    dout
);

  localparam int unsigned IdxBits = $clog2(VALUE_WIDTH);

  state_t state, state_next;

  logic [RadixBits-1:0]   radix;
  logic [RadixBits-1:0]   div_r;
  logic [VALUE_WIDTH-1:0] quot;
  logic [DigitBits-1:0]   rem;
  logic                   qnz;
  logic [IdxBits-1:0]     bit_cnt;
  logic [IdxBits-1:0]     ptr;

  logic [DigitBits-1:0]   mem [VALUE_WIDTH];
  logic [DigitBits-1:0]   rd_data;

  logic [DigitBits-1:0]   out_digit;
  logic                   out_last;
  logic                   out_valid;

  logic                   accept;
  logic                   load;
  logic                   ge;
  logic                   bit_done;
  logic [RadixBits-1:0]   rem_sh;
  logic [RadixBits-1:0]   rem_next;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;

  // One restoring division step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh   = {rem, quot[VALUE_WIDTH-1]};
    ge       = (rem_sh >= div_r);
    rem_next = ge ? (rem_sh - div_r) : rem_sh;
    bit_done = (bit_cnt == '0);
    raw      = din.value[VALUE_WIDTH-1:0];
    mag      = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (din.valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (bit_done && !(qnz || ge)) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || dout.ready) begin
          state_next = (ptr == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready = (state == ST_IDLE);
    cfg.ready = 1'b1;
    accept    = din.valid && (state == ST_IDLE);
    load      = (state == ST_OUT) && (!out_valid || dout.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radix     <= RadixReset;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        radix <= clamp_radix(cfg.radix);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Digits come out least significant first and are stored, then read back in reverse.
  always_ff @(posedge clk) begin
    if (accept) begin
      quot    <= mag;
      div_r   <= radix;
      rem     <= '0;
      qnz     <= 1'b0;
      bit_cnt <= IdxBits'(VALUE_WIDTH - 1);
      ptr     <= '0;
    end else if (state == ST_DIV) begin
      if (bit_done) begin
        mem[ptr] <= rem_next[DigitBits-1:0];
        quot     <= {quot[VALUE_WIDTH-2:0], ge};
        rem      <= '0;
        qnz      <= 1'b0;
        bit_cnt  <= IdxBits'(VALUE_WIDTH - 1);
        if (qnz || ge) ptr <= ptr + IdxBits'(1);
      end else begin
        quot    <= {quot[VALUE_WIDTH-2:0], ge};
        rem     <= rem_next[DigitBits-1:0];
        qnz     <= qnz | ge;
        bit_cnt <= bit_cnt - IdxBits'(1);
      end
    end else if (state == ST_READ) begin
      rd_data <= mem[ptr];
    end else if (load) begin
      out_digit <= rd_data;
      out_last  <= (ptr == '0);
      if (ptr != '0) ptr <= ptr - IdxBits'(1);
    end
  end

  assign dout.valid = out_valid;
  assign dout.digit = out_digit;
  assign dout.last  = out_last;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < div_r))
    else $error("partial remainder reached the radix");

  a_start_division: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_DIV) && (ptr == '0) && (bit_cnt == IdxBits'(VALUE_WIDTH - 1)))
    else $error("division did not start cleanly after a request");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (load && (ptr == '0)) |=> (state == ST_IDLE) && dout.last && dout.valid)
    else $error("final digit not flagged or converter not idle");

endmodule
`default_nettype wire

### tb/tb_integer_to_radix_digits.sv
// Self-checking testbench for the integer to radix digit converter.
module tb_integer_to_radix_digits;
  import itr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [0:0] {
    ROW_RADIX,
    ROW_VALUE
  } row_kind_t;

  // Digits in exp are packed most significant first, the final digit in exp[7:0].
  // A row with n_exp of zero is checked against the predictor instead.
  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] data;
    logic [3:0]  n_exp;
    logic [31:0] exp;
  } stim_row_t;

  typedef struct packed {
    logic [DigitBits-1:0] digit;
    logic                 last;
  } digit_res_t;

  localparam int HOLD_CYCLES    = 600;
  // The longest quiet stretch is one full 64-digit conversion on top of the long
  // output hold; this leaves several times that.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 16;

  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam stim_row_t DIRECTED [29] = '{
    '{ROW_VALUE, 64'd0,                  4'd1, 32'h0000_0000},
    '{ROW_VALUE, 64'd9,                  4'd1, 32'h0000_0009},
    '{ROW_VALUE, 64'd10,                 4'd2, 32'h0000_0100},
    '{ROW_VALUE, ALL_ONE,                4'd1, 32'h0000_0001},
    '{ROW_VALUE, MAX_POS,                4'd0, 32'h0},
    '{ROW_VALUE, MIN_NEG,                4'd0, 32'h0},
    '{ROW_RADIX, 64'd2,                  4'd0, 32'h0},
    '{ROW_VALUE, 64'd5,                  4'd3, 32'h0001_0001},
    '{ROW_VALUE, 64'hFFFF_FFFF_FFFF_FFFE, 4'd2, 32'h0000_0100},
    '{ROW_VALUE, MIN_NEG,                4'd0, 32'h0},
    '{ROW_RADIX, 64'd256,                4'd0, 32'h0},
    '{ROW_VALUE, 64'h0000_0000_0000_FF01, 4'd2, 32'h0000_FF01},
    '{ROW_VALUE, 64'hFFFF_FFFF_FFFF_FF00, 4'd2, 32'h0000_0100},
    '{ROW_VALUE, MAX_POS,                4'd0, 32'h0},
    '{ROW_VALUE, MIN_NEG,                4'd0, 32'h0},
    '{ROW_RADIX, 64'd0,                  4'd0, 32'h0},
    '{ROW_VALUE, 64'd6,                  4'd3, 32'h0001_0100},
    '{ROW_RADIX, 64'd1,                  4'd0, 32'h0},
    '{ROW_VALUE, 64'd3,                  4'd2, 32'h0000_0101},
    '{ROW_RADIX, 64'd511,                4'd0, 32'h0},
    '{ROW_VALUE, 64'd256,                4'd2, 32'h0000_0100},
    '{ROW_RADIX, 64'd257,                4'd0, 32'h0},
    '{ROW_VALUE, 64'd255,                4'd1, 32'h0000_00FF},
    '{ROW_RADIX, 64'd3,                  4'd0, 32'h0},
    '{ROW_VALUE, 64'd8,                  4'd2, 32'h0000_0202},
    '{ROW_VALUE, 64'd9,                  4'd3, 32'h0001_0000},
    '{ROW_RADIX, 64'd7,                  4'd0, 32'h0},
    '{ROW_VALUE, 64'hDEAD_BEEF_0123_4567, 4'd0, 32'h0},
    '{ROW_VALUE, 64'd0,                  4'd1, 32'h0000_0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  itr_cfg_if   radix_ch ();
  itr_value_if value_ch ();
  itr_digit_if digit_ch ();

  integer_to_radix_digits dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (radix_ch),
    .din  (value_ch),
    .dout (digit_ch)
  );

  digit_res_t     digits_due [$];
  logic [8:0]     radix_now = RadixReset;
  int             send_gap_pct = 18;
  int             recv_gap_pct = 85;
  int             holds_asked = 0;
  int             fail_count = 0;
  int             digits_checked = 0;
  int             values_sent = 0;
  int             radix_writes = 0;

  // Queues the digits of one accepted request under the radix now in force.
  function automatic void predict_digits(input logic [63:0] raw);
    logic [63:0] base;
    logic [63:0] mag;
    logic [63:0] place;
    logic [63:0] d;
    if (radix_now < RadixMin) begin
      base = 64'(RadixMin);
    end else if (radix_now > RadixMax) begin
      base = 64'(RadixMax);
    end else begin
      base = 64'(radix_now);
    end
    mag = raw[63] ? (~raw + 64'd1) : raw;
    place = 64'd1;
    while (mag / place >= base) begin
      place = place * base;
    end
    do begin
      d = mag / place;
      mag = mag % place;
      place = place / base;
      digits_due.push_back('{d[7:0], place == 64'd0});
    end while (place != 64'd0);
  endfunction

  // Mostly values of random bit length, with powers of the base and the extremes mixed in.
  function automatic logic [63:0] pick_value();
    logic [63:0] base;
    logic [63:0] v;
    int          len;
    int          k;
    base = (radix_now < RadixMin) ? 64'(RadixMin) :
           (radix_now > RadixMax) ? 64'(RadixMax) : 64'(radix_now);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 64'd0;
          1: v = MAX_POS;
          2: v = MIN_NEG;
          default: v = ALL_ONE;
        endcase
      end
      1, 2: begin
        v = 64'd1;
        k = $urandom_range(0, 63);
        for (int i = 0; i < k && v <= ALL_ONE / base; i++) begin
          v = v * base;
        end
        v = v + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(1) == 1) v = -v;
      end
      default: begin
        len = $urandom_range(1, 64);
        v = {$urandom, $urandom};
        if (len < 64) v = v & ((64'd1 << len) - 64'd1);
        if (len < 64 && $urandom_range(1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [8:0] pick_radix();
    case ($urandom_range(7))
      0: return 9'($urandom_range(0, 1));
      1: return 9'($urandom_range(257, 511));
      2: return 9'd2;
      3: return 9'd256;
      default: return 9'($urandom_range(3, 255));
    endcase
  endfunction

  // Returns at the edge where the request is taken; valid is left high so that
  // back-to-back requests need no second assignment in one step.
  task automatic offer_value(input logic [63:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      value_ch.valid <= 1'b0;
      @(posedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= v;
    @(posedge clk);
    while (!value_ch.ready) @(posedge clk);
    values_sent++;
  endtask

  task automatic wait_idle();
    value_ch.valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [8:0] r);
    radix_ch.valid <= 1'b1;
    radix_ch.radix <= r;
    @(posedge clk);
    while (!radix_ch.ready) @(posedge clk);
    radix_now = r;
    radix_writes++;
    radix_ch.valid <= 1'b0;
  endtask

  // Digit receiver: random back-pressure, plus a long hold whenever one is asked for.
  initial begin
    int hold_left;
    int holds_granted;
    digit_ch.ready = 1'b0;
    hold_left = 0;
    holds_granted = 0;
    forever begin
      @(posedge clk);
      if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        digit_ch.ready <= 1'b0;
      end else begin
        digit_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    digit_res_t want;
    if (!rst && digit_ch.valid && digit_ch.ready) begin
      digits_checked++;
      if (digits_due.size() == 0) begin
        $error("digit %0d (last %0b) arrived with no request outstanding",
               digit_ch.digit, digit_ch.last);
        fail_count++;
      end else begin
        want = digits_due.pop_front();
        if (digit_ch.digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, digit_ch.digit);
          fail_count++;
        end
        if (digit_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, digit_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    int quiet_cycles;
    if ((radix_ch.valid && radix_ch.ready) || (value_ch.valid && value_ch.ready) ||
        (digit_ch.valid && digit_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d digits still due",
                 quiet_cycles, digits_due.size());
        $display("tb_integer_to_radix_digits: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] v;
    stim_row_t   row;
    radix_ch.valid = 1'b0;
    radix_ch.radix = '0;
    value_ch.valid = 1'b0;
    value_ch.value = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run under the first idling pattern; radix writes wait for the block to drain.
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_RADIX) begin
        wait_idle();
        write_radix(row.data[8:0]);
      end else begin
        offer_value(row.data);
        if (row.n_exp == 4'd0) begin
          predict_digits(row.data);
        end else begin
          for (int k = int'(row.n_exp) - 1; k >= 0; k--) begin
            digits_due.push_back('{row.exp[8*k +: 8], k == 0});
          end
        end
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 18;
          recv_gap_pct = 85;
        end
        1: begin
          send_gap_pct = 85;
          recv_gap_pct = 18;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      for (int grp = 0; grp < 4; grp++) begin
        wait_idle();
        write_radix(pick_radix());
        // Short requests behind a long output hold fill the block until it refuses input.
        if (phase == 2 && grp == 0) holds_asked++;
        for (int n = 0; n < 10; n++) begin
          if (phase == 2 && grp == 0) begin
            v = 64'($urandom_range(0, 255));
            if ($urandom_range(1) == 1) v = -v;
          end else begin
            v = pick_value();
          end
          offer_value(v);
          predict_digits(v);
        end
      end
    end

    wait_idle();
    $display("Converted %0d values across %0d radix writes, including out-of-range bases.",
             values_sent, radix_writes);
    $display("Checked %0d digits under both idling patterns and a long output hold.",
             digits_checked);
    if (fail_count == 0) begin
      $display("tb_integer_to_radix_digits: clean");
    end else begin
      $display("tb_integer_to_radix_digits: errors");
    end
    $finish;
  end

endmodule

### integer_to_radix_digits.f
hw/rtl/itr_pkg.sv
hw/rtl/itr_channels.sv
hw/rtl/integer_to_radix_digits.sv
tb/tb_integer_to_radix_digits.sv
